// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/lbmc_pkg.sv =====
package lbmc_pkg;

    // Field widths
    localparam int CMD_W   = 4;
    localparam int HC_W    = 16;
    localparam int HP_W    = 8;
    localparam int DUTY_W  = 8;
    localparam int LEVEL_W = 3;
    localparam int GAP_W   = 3;

    // Remainder pipeline: bits of hold count consumed per stage
    localparam int REM_STEPS  = 4;
    localparam int REM_STAGES = HC_W / REM_STEPS;

    // Event codes
    localparam logic [CMD_W-1:0] CMD_PRESS    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CLICK1   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_CLICK2   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CLICK3   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_HOLD     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_HOT      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_COOL     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_TICK     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_LOW_VOLT = 4'd9;

    // Reset values and limits
    localparam int                 TOP_LEVEL_DEF      = 6;
    localparam logic [HP_W-1:0]    HOLD_PERIOD_RST    = 8'd24;
    localparam logic [LEVEL_W-1:0] REMEMBERED_RST     = 3'd1;
    localparam logic [GAP_W-1:0]   STROBE_GAP_RST     = 3'd2;
    localparam logic [GAP_W:0]     STROBE_SPEEDS      = 4'd6;
    localparam logic [GAP_W-1:0]   FLASH_LONG_GAP     = 3'd3;
    localparam logic [LEVEL_W-1:0] TABLE_LAST         = 3'd6;

    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_STEADY,
        MODE_STROBE
    } mode_t;

    // Item moving through the remainder pipeline
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [HC_W-1:0]  num;
        logic [HP_W-1:0]  rem;
    } rem_item_t;

    // Result item
    typedef struct packed {
        logic                flash_long;
        logic                flash;
        logic [LEVEL_W-1:0]  level_now;
        mode_t               mode_now;
        logic [DUTY_W-1:0]   duty_boost;
        logic [DUTY_W-1:0]   duty_main;
    } res_t;

    // Level tables; indexes above the last entry read the last entry
    function automatic logic [DUTY_W-1:0] main_lut(input logic [LEVEL_W-1:0] lv);
        logic [DUTY_W-1:0] d;
        case (lv)
            3'd0:    d = 8'd3;
            3'd1:    d = 8'd18;
            3'd2:    d = 8'd110;
            3'd3:    d = 8'd255;
            3'd4:    d = 8'd255;
            3'd5:    d = 8'd255;
            default: d = 8'd0;
        endcase
        return d;
    endfunction

    function automatic logic [DUTY_W-1:0] boost_lut(input logic [LEVEL_W-1:0] lv);
        logic [DUTY_W-1:0] d;
        case (lv)
            3'd0:    d = 8'd0;
            3'd1:    d = 8'd0;
            3'd2:    d = 8'd0;
            3'd3:    d = 8'd9;
            3'd4:    d = 8'd58;
            3'd5:    d = 8'd138;
            default: d = 8'd255;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/lbmc_rem_stage.sv =====
module lbmc_rem_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [lbmc_pkg::HP_W-1:0] hold_period,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lbmc_pkg::rem_item_t     in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output lbmc_pkg::rem_item_t     out_item
);
    import lbmc_pkg::*;

    logic      valid_reg;
    rem_item_t item_reg;
    rem_item_t item_next;

    // Restoring remainder steps, one dividend bit each
    always_comb
    begin
        logic [HP_W:0] r;
        item_next = in_item;
        for (int i = 0; i < REM_STEPS; i++)
        begin
            r = {item_next.rem, item_next.num[HC_W-1]};
            if (r >= {1'b0, hold_period})
            begin
                r = r - {1'b0, hold_period};
            end
            item_next.rem = r[HP_W-1:0];
            item_next.num = {item_next.num[HC_W-2:0], 1'b0};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/lbmc_mode_ctrl.sv =====
module lbmc_mode_ctrl #(
    parameter int TOP_LEVEL = lbmc_pkg::TOP_LEVEL_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [lbmc_pkg::CMD_W-1:0] in_cmd,
    input  logic                       in_step,
    output logic                       out_valid,
    input  logic                       out_ready,
    output lbmc_pkg::res_t             out_res
);
    import lbmc_pkg::*;

    localparam logic [LEVEL_W:0]   TopLvl  = (LEVEL_W + 1)'(TOP_LEVEL);
    localparam logic [LEVEL_W-1:0] TopLow  = TopLvl[LEVEL_W-1:0];
    // Level after a hold step, indexed by the current level
    localparam logic [LEVEL_W-1:0] WRAP_TAB [8] = '{
        3'(1 % (TOP_LEVEL + 1)), 3'(2 % (TOP_LEVEL + 1)),
        3'(3 % (TOP_LEVEL + 1)), 3'(4 % (TOP_LEVEL + 1)),
        3'(5 % (TOP_LEVEL + 1)), 3'(6 % (TOP_LEVEL + 1)),
        3'(7 % (TOP_LEVEL + 1)), 3'(8 % (TOP_LEVEL + 1))
    };

    mode_t              mode_reg, mode_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] remem_reg, remem_next;
    logic [LEVEL_W-1:0] goal_reg, goal_next;
    logic [GAP_W-1:0]   frame_reg, frame_next;
    logic [GAP_W-1:0]   gap_reg, gap_next;
    logic [DUTY_W-1:0]  duty_a_reg, duty_a_next;
    logic [DUTY_W-1:0]  duty_b_reg, duty_b_next;
    logic               out_valid_reg;
    res_t               res_reg, res_next;
    logic               accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // Event handling per mode
    always_comb
    begin
        logic [LEVEL_W-1:0] lv;
        logic               apply;
        logic               go_off;
        logic               flash;
        logic               flash_long;
        logic [GAP_W:0]     inc;

        mode_next   = mode_reg;
        level_next  = level_reg;
        remem_next  = remem_reg;
        goal_next   = goal_reg;
        frame_next  = frame_reg;
        gap_next    = gap_reg;
        duty_a_next = duty_a_reg;
        duty_b_next = duty_b_reg;
        lv          = level_reg;
        apply       = 1'b0;
        go_off      = 1'b0;
        flash       = 1'b0;
        flash_long  = 1'b0;
        inc         = '0;

        case (mode_reg)
            MODE_STEADY:
            begin
                case (in_cmd)
                    CMD_CLICK1: go_off = 1'b1;
                    CMD_CLICK2:
                    begin
                        if ({1'b0, level_reg} < TopLvl)
                        begin
                            remem_next = level_reg;
                            goal_next  = TopLow;
                            lv         = TopLow;
                        end
                        else
                        begin
                            goal_next = remem_reg;
                            lv        = remem_reg;
                        end
                        apply = 1'b1;
                    end
                    CMD_CLICK3:
                    begin
                        mode_next  = MODE_STROBE;
                        frame_next = '0;
                    end
                    CMD_HOLD:
                    begin
                        if (in_step)
                        begin
                            remem_next = WRAP_TAB[level_reg];
                            goal_next  = WRAP_TAB[level_reg];
                            lv         = WRAP_TAB[level_reg];
                            apply      = 1'b1;
                        end
                    end
                    CMD_HOT:
                    begin
                        if (level_reg > 3'd1)
                        begin
                            lv    = level_reg - 3'd1;
                            apply = 1'b1;
                        end
                    end
                    CMD_COOL:
                    begin
                        if (level_reg < goal_reg)
                        begin
                            lv    = level_reg + 3'd1;
                            apply = 1'b1;
                        end
                    end
                    CMD_LOW_VOLT:
                    begin
                        if (level_reg != 3'd0)
                        begin
                            lv    = level_reg - 3'd1;
                            apply = 1'b1;
                        end
                        else
                        begin
                            go_off = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_STROBE:
            begin
                case (in_cmd)
                    CMD_TICK:
                    begin
                        if (frame_reg == '0)
                        begin
                            flash       = 1'b1;
                            flash_long  = (gap_reg >= FLASH_LONG_GAP);
                            duty_a_next = '0;
                            duty_b_next = '0;
                        end
                        inc = {1'b0, frame_reg} + 4'd1;
                        frame_next = (inc > {1'b0, gap_reg}) ? '0 : inc[GAP_W-1:0];
                    end
                    CMD_CLICK1: go_off = 1'b1;
                    CMD_CLICK2:
                    begin
                        // Re-enter steady at the remembered level
                        mode_next = MODE_STEADY;
                        goal_next = remem_reg;
                        lv        = remem_reg;
                        apply     = 1'b1;
                    end
                    CMD_HOLD:
                    begin
                        if (in_step)
                        begin
                            inc = {1'b0, gap_reg} + 4'd1;
                            if (inc >= STROBE_SPEEDS)
                            begin
                                inc = inc - STROBE_SPEEDS;
                            end
                            gap_next   = inc[GAP_W-1:0];
                            frame_next = '0;
                        end
                    end
                    CMD_LOW_VOLT:
                    begin
                        mode_next = MODE_STEADY;
                        if (TopLvl > 4'd1)
                        begin
                            remem_next = 3'd1;
                        end
                        goal_next = 3'd1;
                        lv        = 3'd1;
                        apply     = 1'b1;
                    end
                    default: ;
                endcase
            end
            default:
            begin
                case (in_cmd)
                    CMD_PRESS:
                    begin
                        lv    = '0;
                        apply = 1'b1;
                    end
                    CMD_RELEASE:
                    begin
                        lv    = remem_reg;
                        apply = 1'b1;
                    end
                    CMD_CLICK1:
                    begin
                        mode_next = MODE_STEADY;
                        goal_next = remem_reg;
                        lv        = remem_reg;
                        apply     = 1'b1;
                    end
                    CMD_CLICK2:
                    begin
                        mode_next = MODE_STEADY;
                        goal_next = TopLow;
                        lv        = TopLow;
                        apply     = 1'b1;
                    end
                    CMD_CLICK3:
                    begin
                        mode_next  = MODE_STROBE;
                        frame_next = '0;
                    end
                    CMD_HOLD:
                    begin
                        mode_next = MODE_STEADY;
                        goal_next = '0;
                        lv        = '0;
                        apply     = 1'b1;
                    end
                    default: ;
                endcase
            end
        endcase

        // Level apply: table lookup with clamp to the last entry
        if (apply)
        begin
            level_next  = lv;
            duty_a_next = main_lut((lv > TABLE_LAST) ? TABLE_LAST : lv);
            duty_b_next = boost_lut((lv > TABLE_LAST) ? TABLE_LAST : lv);
        end
        if (go_off)
        begin
            mode_next   = MODE_OFF;
            duty_a_next = '0;
            duty_b_next = '0;
        end

        res_next.duty_main  = duty_a_next;
        res_next.duty_boost = duty_b_next;
        res_next.mode_now   = mode_next;
        res_next.level_now  = level_next;
        res_next.flash      = flash;
        res_next.flash_long = flash_long;
    end

    // Mode state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            level_reg     <= '0;
            remem_reg     <= REMEMBERED_RST;
            goal_reg      <= '0;
            frame_reg     <= '0;
            gap_reg       <= STROBE_GAP_RST;
            duty_a_reg    <= '0;
            duty_b_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                level_reg  <= level_next;
                remem_reg  <= remem_next;
                goal_reg   <= goal_next;
                frame_reg  <= frame_next;
                gap_reg    <= gap_next;
                duty_a_reg <= duty_a_next;
                duty_b_reg <= duty_b_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== sv/led_brightness_mode_controller_unit.sv =====
// Pipeline: 4 remainder stages, then the result register.
// Throughput: one event per cycle while m_tready is high; the hold-count remainder pipeline and the
// registered mode update both take a new item every cycle while the output is not stalled.
// Reset: rst_n is asynchronous, active low; mode off, level 0, remembered level 1,
// strobe gap 2, duties 0, hold period 24, pipeline empty.
module led_brightness_mode_controller_unit #(
    parameter int TOP_LEVEL = lbmc_pkg::TOP_LEVEL_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,   // hold_period
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] hold_count
    input  logic [3:0]  s_tuser,     // [3:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata      // [7:0] duty_main, [15:8] duty_boost, [17:16] mode_now,
                                     // [20:18] level_now, [21] flash, [22] flash_long, [23] zero
);
    import lbmc_pkg::*;

    logic [HP_W-1:0] hold_period_reg;
    logic            link_valid [REM_STAGES+1];
    logic            link_ready [REM_STAGES+1];
    rem_item_t       link_item  [REM_STAGES+1];
    logic            step;
    res_t            res;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_period_reg <= HOLD_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            hold_period_reg <= cfg_wdata;
        end
    end

    // Pipeline entry
    assign link_valid[0] = s_tvalid;
    assign s_tready      = link_ready[0];
    assign link_item[0]  = '{cmd: s_tuser, num: s_tdata, rem: '0};

    // Hold-count remainder stages
    for (genvar g = 0; g < REM_STAGES; g++)
    begin : g_rem
        lbmc_rem_stage u_stage (
            .clk         (clk),
            .rst_n       (rst_n),
            .hold_period (hold_period_reg),
            .in_valid    (link_valid[g]),
            .in_ready    (link_ready[g]),
            .in_item     (link_item[g]),
            .out_valid   (link_valid[g+1]),
            .out_ready   (link_ready[g+1]),
            .out_item    (link_item[g+1])
        );
    end

    // Hold step fires when the period divides the hold count
    assign step = (hold_period_reg != '0) && (link_item[REM_STAGES].rem == '0);

    lbmc_mode_ctrl #(
        .TOP_LEVEL (TOP_LEVEL)
    ) u_mode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (link_valid[REM_STAGES]),
        .in_ready  (link_ready[REM_STAGES]),
        .in_cmd    (link_item[REM_STAGES].cmd),
        .in_step   (step),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {1'b0, res};

endmodule

// ===== sv/lbmc_checker.sv =====
`include "assert_macros.svh"

module lbmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import lbmc_pkg::*;

    logic flash_seen;
    logic flash_dark;

    assign flash_seen = m_tvalid && m_tdata[21];
    assign flash_dark = (m_tdata[15:0] == 16'd0) && (m_tdata[17:16] == MODE_STROBE);

    // A long pulse is only reported with a flash
    `ASSERT_IMPLY(a_long_needs_flash, clk, rst_n, m_tvalid && m_tdata[22], m_tdata[21])

    // A flash happens in strobe mode and leaves both duties dark
    `ASSERT_IMPLY(a_flash_dark, clk, rst_n, flash_seen, flash_dark)

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind led_brightness_mode_controller_unit lbmc_checker u_lbmc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
